>>> rtl/line_column_field_cutter_unit_assert.svh
// Assertion macros used by the line/column field cutter back end.
`ifndef LINE_COLUMN_FIELD_CUTTER_UNIT_ASSERT_SVH
`define LINE_COLUMN_FIELD_CUTTER_UNIT_ASSERT_SVH

// Implication checked at every rising clock edge, off during reset
`define LCFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never hold outside reset
`define LCFC_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/lcfc_pkg.sv
// Package: constants, types and range match function for the field cutter.
package lcfc_pkg;

  localparam int DATA_W  = 8;
  localparam int POS_W   = 16;
  localparam int CNT_W   = 6;
  localparam int QUEUE_DEPTH = 4;

  localparam int DEF_RANGE_SLOTS = 8;
  localparam int DEF_HOLD_BYTES  = 63;

  localparam logic [POS_W-1:0]  POS_MAX      = 16'hFFFF;
  localparam logic [DATA_W-1:0] NEWLINE_BYTE = 8'd10;
  localparam logic [DATA_W-1:0] TAB_BYTE     = 8'd9;

  // Configuration register indexes
  typedef enum logic [3:0] {
    REG_SELECT_FIELDS = 4'd0,
    REG_DELIMITER     = 4'd1,
    REG_SUPPRESS      = 4'd2,
    REG_RANGE_COUNT   = 4'd3,
    REG_RANGE_PAIR_0  = 4'd4,
    REG_RANGE_PAIR_1  = 4'd5,
    REG_RANGE_PAIR_2  = 4'd6,
    REG_RANGE_PAIR_3  = 4'd7
  } cfg_reg_t;

  // Configuration seen by the front end
  typedef struct packed {
    logic              select_fields;
    logic [DATA_W-1:0] delimiter;
    logic              suppress_undelimited;
    logic [3:0]        range_count;
    logic [3:0][63:0]  range_pair;
  } cfg_t;

  // Command from front to back: optional hold flush, then optional byte
  typedef struct packed {
    logic [CNT_W-1:0]  flush_count;
    logic              has_byte;
    logic [DATA_W-1:0] out_byte;
    logic              line_done;
    logic              ovf;
  } cmd_t;

  // Hold memory write port
  typedef struct packed {
    logic              en;
    logic [CNT_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } hold_wr_t;

  // True when pos lies in any of the first n ranges
  function automatic logic in_ranges(input logic [POS_W-1:0] pos,
                                     input logic [3:0][63:0] pairs,
                                     input logic [3:0] n);
    logic             hit;
    logic [31:0]      word;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    hit = 1'b0;
    for (int k = 0; k < 8; k++) begin
      word = pairs[k/2][(k%2)*32 +: 32];
      lo   = word[15:0];
      hi   = word[31:16];
      if ((4'(k) < n) && (pos >= lo) && ((hi == '0) || (pos <= hi))) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

>>> rtl/lcfc_queue.sv
// Small command queue between the front and back ends.
module lcfc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  lcfc_pkg::cmd_t wr_cmd,
  input  logic          rd_en,
  output logic          full,
  output logic          valid,
  output lcfc_pkg::cmd_t head
);
  import lcfc_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t            slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;

  assign full  = (count == (PW+1)'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/lcfc_front.sv
// Front end: accepts bytes, tracks line state, fills the hold, issues commands.
module lcfc_front #(
  parameter int RANGE_SLOTS = lcfc_pkg::DEF_RANGE_SLOTS,
  parameter int HOLD_BYTES  = lcfc_pkg::DEF_HOLD_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lcfc_pkg::cfg_t                cfg,
  input  logic                          push,
  input  logic                          mode,
  input  logic [lcfc_pkg::DATA_W-1:0]   in_byte,
  output logic                          full,
  input  logic                          q_full,
  output logic                          cmd_push,
  output lcfc_pkg::cmd_t                cmd,
  output lcfc_pkg::hold_wr_t            hold_wr,
  input  logic                          flush_end
);
  import lcfc_pkg::*;

  localparam int CW = $clog2(HOLD_BYTES + 1);

  logic [POS_W-1:0] char_position, char_position_next;
  logic [POS_W-1:0] field_number, field_number_next;
  logic             delimiter_seen, delimiter_seen_next;
  logic             any_field_emitted, any_field_emitted_next;
  logic [CW-1:0]    hold_count, hold_count_next;
  logic             hold_lost, hold_lost_next;
  logic             flush_wait, flush_wait_next;

  logic             accept;
  logic             is_delim;
  logic [3:0]       n_active;
  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] fn_inc;
  logic [POS_W-1:0] probe;
  logic             hit, hit1, hit2;

  // Input stalls on a full queue or while a hold flush drains
  assign full   = q_full || flush_wait;
  assign accept = push && !full;

  assign is_delim = (in_byte == cfg.delimiter);
  assign n_active = (cfg.range_count > 4'(RANGE_SLOTS)) ? 4'(RANGE_SLOTS) : cfg.range_count;
  assign pos_inc  = (char_position == POS_MAX) ? char_position : char_position + 1'b1;
  assign fn_inc   = (field_number == POS_MAX) ? field_number : field_number + 1'b1;

  // One range probe for the current position or field, two fixed ones for fields 1 and 2
  always_comb begin
    if (!cfg.select_fields) probe = pos_inc;
    else if (is_delim)      probe = fn_inc;
    else                    probe = field_number;
  end
  assign hit  = in_ranges(probe, cfg.range_pair, n_active);
  assign hit1 = in_ranges(POS_W'(1), cfg.range_pair, n_active);
  assign hit2 = in_ranges(POS_W'(2), cfg.range_pair, n_active);

  // Item classification
  always_comb begin
    char_position_next     = char_position;
    field_number_next      = field_number;
    delimiter_seen_next    = delimiter_seen;
    any_field_emitted_next = any_field_emitted;
    hold_count_next        = hold_count;
    hold_lost_next         = hold_lost;
    cmd_push               = 1'b0;
    cmd                    = '0;
    hold_wr                = '0;

    if (accept) begin
      if (!cfg.select_fields) begin
        // character positions
        if (mode) begin
          cmd_push = 1'b1;
          cmd.has_byte  = 1'b1;
          cmd.out_byte  = NEWLINE_BYTE;
          cmd.line_done = 1'b1;
        end else begin
          char_position_next = pos_inc;
          if (hit) begin
            cmd_push = 1'b1;
            cmd.has_byte = 1'b1;
            cmd.out_byte = in_byte;
          end
        end
      end else if (mode) begin
        // end of line in field mode
        cmd.ovf = hold_lost;
        if (delimiter_seen) begin
          cmd_push = 1'b1;
          cmd.has_byte  = 1'b1;
          cmd.out_byte  = NEWLINE_BYTE;
          cmd.line_done = 1'b1;
        end else if (!cfg.suppress_undelimited) begin
          cmd_push = 1'b1;
          cmd.flush_count = CNT_W'(hold_count);
          cmd.has_byte    = 1'b1;
          cmd.out_byte    = NEWLINE_BYTE;
          cmd.line_done   = 1'b1;
        end
      end else if (!delimiter_seen) begin
        if (is_delim) begin
          // first delimiter: release the held first field if it is selected
          delimiter_seen_next    = 1'b1;
          field_number_next      = POS_W'(2);
          any_field_emitted_next = hit1 || hit2;
          cmd.flush_count = hit1 ? CNT_W'(hold_count) : '0;
          cmd.has_byte    = hit1 && hit2;
          cmd.out_byte    = cfg.delimiter;
          cmd.ovf         = hold_lost;
          cmd_push = (cmd.flush_count != '0) || cmd.has_byte;
        end else if (hold_count < CW'(HOLD_BYTES)) begin
          hold_wr.en      = 1'b1;
          hold_wr.addr    = CNT_W'(hold_count);
          hold_wr.data    = in_byte;
          hold_count_next = hold_count + 1'b1;
        end else begin
          hold_lost_next = 1'b1;
        end
      end else begin
        // delimited line, later fields
        cmd.ovf = hold_lost;
        if (is_delim) begin
          field_number_next = fn_inc;
          if (hit) begin
            any_field_emitted_next = 1'b1;
            if (any_field_emitted) begin
              cmd_push = 1'b1;
              cmd.has_byte = 1'b1;
              cmd.out_byte = cfg.delimiter;
            end
          end
        end else if (hit) begin
          cmd_push = 1'b1;
          cmd.has_byte = 1'b1;
          cmd.out_byte = in_byte;
        end
      end

      // every end of line clears the line state
      if (mode) begin
        char_position_next     = '0;
        field_number_next      = POS_W'(1);
        delimiter_seen_next    = 1'b0;
        any_field_emitted_next = 1'b0;
        hold_count_next        = '0;
        hold_lost_next         = 1'b0;
      end
    end
  end

  // Flush interlock: hold entries stay put until the back end has read them
  always_comb begin
    flush_wait_next = flush_wait;
    if (flush_end) flush_wait_next = 1'b0;
    if (cmd_push && (cmd.flush_count != '0)) flush_wait_next = 1'b1;
  end

  // Line state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      char_position     <= '0;
      field_number      <= POS_W'(1);
      delimiter_seen    <= 1'b0;
      any_field_emitted <= 1'b0;
      hold_count        <= '0;
      hold_lost         <= 1'b0;
      flush_wait        <= 1'b0;
    end else begin
      char_position     <= char_position_next;
      field_number      <= field_number_next;
      delimiter_seen    <= delimiter_seen_next;
      any_field_emitted <= any_field_emitted_next;
      hold_count        <= hold_count_next;
      hold_lost         <= hold_lost_next;
      flush_wait        <= flush_wait_next;
    end
  end

endmodule

>>> rtl/lcfc_back.sv
// Back end: hold memory, flush sequencer and output register.
module lcfc_back #(
  parameter int HOLD_BYTES = lcfc_pkg::DEF_HOLD_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lcfc_pkg::hold_wr_t            hold_wr,
  input  logic                          cmd_valid,
  input  lcfc_pkg::cmd_t                cmd_head,
  output logic                          cmd_take,
  output logic                          flush_end,
  output logic                          empty,
  input  logic                          pop,
  output logic [lcfc_pkg::DATA_W-1:0]   out_byte,
  output logic                          line_done,
  output logic                          hold_overflow
);
  import lcfc_pkg::*;

  `include "line_column_field_cutter_unit_assert.svh"

  localparam int CW = $clog2(HOLD_BYTES + 1);
  localparam int AW = (HOLD_BYTES > 1) ? $clog2(HOLD_BYTES) : 1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FLUSH = 3'b010,
    S_TAIL  = 3'b100
  } back_state_t;

  back_state_t       state, state_next;
  logic [CW-1:0]     idx, idx_next;
  logic [CW-1:0]     cnt;
  cmd_t              tail;
  logic [CW-1:0]     rd_idx;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] hold_mem [HOLD_BYTES];

  logic              ob_valid;
  logic [DATA_W-1:0] ob_byte;
  logic              ob_done;
  logic              ob_ovf;
  logic              load_ok;
  logic              load;
  logic [DATA_W-1:0] ld_byte;
  logic              ld_done;
  logic              ld_ovf;
  logic              last;

  // Hold memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (hold_wr.en) begin
      hold_mem[hold_wr.addr[AW-1:0]] <= hold_wr.data;
    end
    rd_data <= hold_mem[rd_idx[AW-1:0]];
  end

  assign load_ok = !ob_valid || pop;
  assign last    = ({1'b0, idx} + 1'b1) == {1'b0, cnt};

  // Flush sequencer
  always_comb begin
    state_next = state;
    idx_next   = idx;
    rd_idx     = idx;
    cmd_take   = 1'b0;
    flush_end  = 1'b0;
    load       = 1'b0;
    ld_byte    = tail.out_byte;
    ld_done    = tail.line_done;
    ld_ovf     = tail.ovf;
    case (state)
      S_IDLE: begin
        rd_idx = '0;
        if (cmd_valid && load_ok) begin
          cmd_take = 1'b1;
          if (cmd_head.flush_count != '0) begin
            state_next = S_FLUSH;
            idx_next   = '0;
          end else begin
            load    = 1'b1;
            ld_byte = cmd_head.out_byte;
            ld_done = cmd_head.line_done;
            ld_ovf  = cmd_head.ovf;
          end
        end
      end
      S_FLUSH: begin
        if (load_ok) begin
          load    = 1'b1;
          ld_byte = rd_data;
          ld_done = 1'b0;
          if (last) begin
            flush_end  = 1'b1;
            state_next = tail.has_byte ? S_TAIL : S_IDLE;
          end else begin
            idx_next = idx + 1'b1;
            rd_idx   = idx + 1'b1;
          end
        end
      end
      S_TAIL: begin
        if (load_ok) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // Command capture for flush length and tail byte
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cnt  <= cmd_head.flush_count[CW-1:0];
      tail <= cmd_head;
    end
  end

  // Output register: one result transaction waits here
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_valid <= 1'b0;
    end else if (load) begin
      ob_valid <= 1'b1;
    end else if (pop) begin
      ob_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ob_byte <= ld_byte;
      ob_done <= ld_done;
      ob_ovf  <= ld_ovf;
    end
  end

  assign empty         = !ob_valid;
  assign out_byte      = ob_byte;
  assign line_done     = ob_done;
  assign hold_overflow = ob_ovf;

  // Checks
  `LCFC_ASSERT(a_flush_bounds, (state == S_FLUSH) |-> (cnt != '0 && idx < cnt),
               "flush index outside captured length")
  `LCFC_ASSERT(a_tail_has_byte, (state == S_TAIL) |-> tail.has_byte,
               "tail state without a tail byte")
  `LCFC_NEVER(a_take_when_busy, cmd_take && (state != S_IDLE),
              "command taken while a flush is running")
  `LCFC_ASSERT(a_done_is_newline, (ob_valid && ob_done) |-> (ob_byte == NEWLINE_BYTE),
               "line end marked on a byte other than newline")

endmodule

>>> rtl/line_column_field_cutter_unit.sv
// Top level of the line/column field cutter: config registers and block wiring.
// Cuts text lines by character position or by delimited field, like the cut
// utility. Bytes enter through a push/full queue port, one transaction per
// byte or end-of-line mark, and results leave through an empty/pop port.
// In character mode and on delimited lines new items enter while earlier ones
// wait in the queue. In field mode the first field is held in a HOLD_BYTES-deep
// memory until the first delimiter or the end of line; releasing it drains the
// hold through the back end at one byte per cycle from its single read port
// while the output is popped, and the input reports full until the drain ends.
// A four-entry command queue separates input classification from output, and
// results stall only when the output register is not popped. The config port
// is always ready; write it only while the block is idle.
module line_column_field_cutter_unit #(
  parameter int RANGE_SLOTS = lcfc_pkg::DEF_RANGE_SLOTS,
  parameter int HOLD_BYTES  = lcfc_pkg::DEF_HOLD_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  // input queue port
  input  logic                          push,
  output logic                          full,
  input  logic                          mode,
  input  logic [lcfc_pkg::DATA_W-1:0]   in_byte,
  // result queue port
  output logic                          empty,
  input  logic                          pop,
  output logic [lcfc_pkg::DATA_W-1:0]   out_byte,
  output logic                          line_done,
  output logic                          hold_overflow,
  // config write port
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [3:0]                    cfg_index,
  input  logic [63:0]                   cfg_data
);
  import lcfc_pkg::*;

  cfg_t     cfg;
  cmd_t     cmd, q_head;
  hold_wr_t hold_wr;
  logic     cmd_push, q_full, q_valid, cmd_take, flush_end;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.select_fields        <= 1'b0;
      cfg.delimiter            <= TAB_BYTE;
      cfg.suppress_undelimited <= 1'b0;
      cfg.range_count          <= 4'd1;
      cfg.range_pair           <= {64'd0, 64'd0, 64'd0, 64'd1};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SELECT_FIELDS: cfg.select_fields        <= cfg_data[0];
        REG_DELIMITER:     cfg.delimiter            <= cfg_data[DATA_W-1:0];
        REG_SUPPRESS:      cfg.suppress_undelimited <= cfg_data[0];
        REG_RANGE_COUNT:   cfg.range_count          <= cfg_data[3:0];
        REG_RANGE_PAIR_0:  cfg.range_pair[0]        <= cfg_data;
        REG_RANGE_PAIR_1:  cfg.range_pair[1]        <= cfg_data;
        REG_RANGE_PAIR_2:  cfg.range_pair[2]        <= cfg_data;
        REG_RANGE_PAIR_3:  cfg.range_pair[3]        <= cfg_data;
        default: ;
      endcase
    end
  end

  lcfc_front #(
    .RANGE_SLOTS (RANGE_SLOTS),
    .HOLD_BYTES  (HOLD_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .mode      (mode),
    .in_byte   (in_byte),
    .full      (full),
    .q_full    (q_full),
    .cmd_push  (cmd_push),
    .cmd       (cmd),
    .hold_wr   (hold_wr),
    .flush_end (flush_end)
  );

  lcfc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_push),
    .wr_cmd (cmd),
    .rd_en  (cmd_take),
    .full   (q_full),
    .valid  (q_valid),
    .head   (q_head)
  );

  lcfc_back #(
    .HOLD_BYTES (HOLD_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .hold_wr       (hold_wr),
    .cmd_valid     (q_valid),
    .cmd_head      (q_head),
    .cmd_take      (cmd_take),
    .flush_end     (flush_end),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .line_done     (line_done),
    .hold_overflow (hold_overflow)
  );

endmodule
